// File: hdl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = 17;
	localparam int COORD_W     = 32;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = DIFF_W + T_W + 1;
	localparam int SHR_W       = PROD_W - T_FRAC_BITS;
	localparam int NSTG        = 6;

	typedef logic [T_W-1:0]            t_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [3:0]              pts_t;

	localparam t_t T_ONE = t_t'(1) << T_FRAC_BITS;
	localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

	typedef struct packed {
		t_t     t_param;
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
	} in_word_t;

	typedef struct packed {
		coord_t q0_x;
		coord_t q0_y;
		coord_t q1_x;
		coord_t q1_y;
		coord_t q2_x;
		coord_t q2_y;
		coord_t q3_x;
		coord_t q3_y;
		logic   is_right_half;
	} out_word_t;

endpackage

`default_nettype wire

// File: hdl/cbs_in_if.sv
`default_nettype none

interface cbs_in_if import cbs_pkg::*; ;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cbs_out_if.sv
`default_nettype none

interface cbs_out_if import cbs_pkg::*; ;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cbs_lerp.sv
`default_nettype none

module cbs_lerp import cbs_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  coord_t    a,
	input  coord_t    b,
	input  t_t        t,
	output coord_t    y
);

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_s1;
	coord_t                   a_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [SHR_W-1:0]  shr;
	logic signed [SHR_W-1:0]  sum;
	coord_t                   y_s2;

	assign diff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
			a_s1    <= a;
		end
	end

	// round half up: floor((prod + half) / 2^T)
	assign rnd = prod_s1 + P_HALF;
	assign shr = $signed(rnd[PROD_W-1:T_FRAC_BITS]);
	assign sum = shr + $signed({{(SHR_W-COORD_W){a_s1[COORD_W-1]}}, a_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= sum[COORD_W-1:0];
		end
	end

	assign y = y_s2;

endmodule

`default_nettype wire

// File: hdl/cbs_lane.sv
`default_nettype none

module cbs_lane import cbs_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  t_t        t,
	input  pts_t      p,
	output pts_t      left,
	output pts_t      right
);

	t_t     t_s1, t_s2, t_s3, t_s4;
	coord_t p01, p12, p23, p012, p123, p0123;
	coord_t p0_d   [NSTG];
	coord_t p3_d   [NSTG];
	coord_t p01_d  [NSTG-2];
	coord_t p23_d  [NSTG-2];
	coord_t p012_d [NSTG-4];
	coord_t p123_d [NSTG-4];

	cbs_lerp u_l01 (.clk(clk), .en(en), .a(p[0]), .b(p[1]), .t(t), .y(p01));
	cbs_lerp u_l12 (.clk(clk), .en(en), .a(p[1]), .b(p[2]), .t(t), .y(p12));
	cbs_lerp u_l23 (.clk(clk), .en(en), .a(p[2]), .b(p[3]), .t(t), .y(p23));
	cbs_lerp u_l012 (.clk(clk), .en(en), .a(p01), .b(p12), .t(t_s2), .y(p012));
	cbs_lerp u_l123 (.clk(clk), .en(en), .a(p12), .b(p23), .t(t_s2), .y(p123));
	cbs_lerp u_l0123 (.clk(clk), .en(en), .a(p012), .b(p123), .t(t_s4), .y(p0123));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			t_s2 <= t_s1;
			t_s3 <= t_s2;
			t_s4 <= t_s3;
			p0_d[0]   <= p[0];
			p3_d[0]   <= p[3];
			p01_d[0]  <= p01;
			p23_d[0]  <= p23;
			p012_d[0] <= p012;
			p123_d[0] <= p123;
			for (int i = 1; i < NSTG; i++) begin
				p0_d[i] <= p0_d[i-1];
				p3_d[i] <= p3_d[i-1];
			end
			for (int i = 1; i < NSTG-2; i++) begin
				p01_d[i] <= p01_d[i-1];
				p23_d[i] <= p23_d[i-1];
			end
			for (int i = 1; i < NSTG-4; i++) begin
				p012_d[i] <= p012_d[i-1];
				p123_d[i] <= p123_d[i-1];
			end
		end
	end

	always_comb begin
		left[0]  = p0_d[NSTG-1];
		left[1]  = p01_d[NSTG-3];
		left[2]  = p012_d[NSTG-5];
		left[3]  = p0123;
		right[0] = p0123;
		right[1] = p123_d[NSTG-5];
		right[2] = p23_d[NSTG-3];
		right[3] = p3_d[NSTG-1];
	end

endmodule

`default_nettype wire

// File: hdl/cubic_bezier_subdivide_top.sv
// Path: a curve accepted on din passes three lerp levels of two stages each (prod_s1 then y_s2),
// then the output buffer, which presents the left sub-curve word on dout;
// the right sub-curve word follows in the cycle after the left word is taken (dout.ready high).
// Curve rate is bound by the two output words per curve; din.ready drops while the last stage waits.
// Reset (arst_n low): pipeline valid bits and output buffer state cleared at once.
`default_nettype none

module cubic_bezier_subdivide_top import cbs_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	cbs_in_if.sink    din,
	cbs_out_if.source dout
);

	t_t        t_c;
	pts_t      px, py;
	pts_t      lx, rx, ly, ry;
	logic [NSTG-1:0] v_q;
	logic      obuf_v_q, half_q;
	logic      can_load, load, pipe_en, take;
	out_word_t left_q, right_q;
	out_word_t left_w, right_w;

	assign t_c = (din.data.t_param > T_ONE) ? T_ONE : din.data.t_param;

	always_comb begin
		px[0] = din.data.p0_x;
		px[1] = din.data.p1_x;
		px[2] = din.data.p2_x;
		px[3] = din.data.p3_x;
		py[0] = din.data.p0_y;
		py[1] = din.data.p1_y;
		py[2] = din.data.p2_y;
		py[3] = din.data.p3_y;
	end

	cbs_lane u_lane_x (.clk(clk), .en(pipe_en), .t(t_c), .p(px), .left(lx), .right(rx));
	cbs_lane u_lane_y (.clk(clk), .en(pipe_en), .t(t_c), .p(py), .left(ly), .right(ry));

	assign take     = dout.valid && dout.ready;
	assign can_load = !obuf_v_q || (half_q && dout.ready);
	assign load     = v_q[NSTG-1] && can_load;
	assign pipe_en  = !v_q[NSTG-1] || can_load;
	assign din.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (pipe_en) begin
			v_q <= {v_q[NSTG-2:0], din.valid};
		end
	end

	always_comb begin
		left_w.q0_x  = lx[0];
		left_w.q0_y  = ly[0];
		left_w.q1_x  = lx[1];
		left_w.q1_y  = ly[1];
		left_w.q2_x  = lx[2];
		left_w.q2_y  = ly[2];
		left_w.q3_x  = lx[3];
		left_w.q3_y  = ly[3];
		left_w.is_right_half = 1'b0;
		right_w.q0_x = rx[0];
		right_w.q0_y = ry[0];
		right_w.q1_x = rx[1];
		right_w.q1_y = ry[1];
		right_w.q2_x = rx[2];
		right_w.q2_y = ry[2];
		right_w.q3_x = rx[3];
		right_w.q3_y = ry[3];
		right_w.is_right_half = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_w;
			right_q <= right_w;
		end
	end

	// merge: left word first, then right word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_v_q <= 1'b0;
			half_q   <= 1'b0;
		end else if (load) begin
			obuf_v_q <= 1'b1;
			half_q   <= 1'b0;
		end else if (take) begin
			if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				obuf_v_q <= 1'b0;
				half_q   <= 1'b0;
			end
		end
	end

	assign dout.valid = obuf_v_q;
	assign dout.data  = half_q ? right_q : left_q;

	a_left_then_right: assert property (@(posedge clk) disable iff (!arst_n)
		take && !half_q |=> obuf_v_q && half_q)
		else $error("right word did not follow left word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take && half_q && !load |=> !obuf_v_q)
		else $error("buffer not freed after right word");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> v_q[NSTG-1] && (!obuf_v_q || (half_q && take)))
		else $error("buffer overwritten");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(v_q))
		else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
